[hdl/kofn_pkg.sv]
// Shared types, constants and helpers of the k-of-n event detector.
package kofn_pkg;

  localparam int PROB_W   = 13;
  localparam int DET_W    = 3;
  localparam int CNT_W    = 32;
  localparam int HITS_W   = 4;
  localparam int COOL_W   = 8;
  localparam int HIST_W   = 15;
  localparam int MINH_W   = 20;
  localparam int NUM_THR  = 5;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam logic [PROB_W-1:0] ONE_FIX = 13'd4096;

  typedef enum logic [2:0] {
    REG_THR0,
    REG_THR1,
    REG_THR2,
    REG_THR3,
    REG_THR4,
    REG_MIN_HITS,
    REG_COOLDOWN,
    REG_EMA_WEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_THR-1:0][PROB_W-1:0] thr;
    logic [MINH_W-1:0]              need_table;
    logic [COOL_W-1:0]              cool_len;
    logic [PROB_W-1:0]              ema_w;
  } kofn_cfg_t;

  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic [HITS_W-1:0] hits;
    logic [COOL_W-1:0] cool;
    logic [PROB_W-1:0] ema;
    logic [PROB_W-1:0] peak;
    logic [CNT_W-1:0]  events;
  } kofn_entry_t;

  typedef struct packed {
    logic              detected;
    logic [CNT_W-1:0]  event_count;
    logic [PROB_W-1:0] ema_level;
    logic [PROB_W-1:0] peak_level;
    logic [HITS_W-1:0] hits_in_window;
    logic [COOL_W-1:0] cooldown_left;
  } kofn_result_t;

  function automatic logic [PROB_W-1:0] sat_one(input logic [PROB_W-1:0] v);
    return (v > ONE_FIX) ? ONE_FIX : v;
  endfunction

endpackage

[hdl/kofn_if.sv]
// Valid/ready channel interfaces for the input and result items.
interface kofn_in_if;
  import kofn_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [DET_W-1:0]  detector;
  logic [PROB_W-1:0] probability;
  modport source(output valid, mode, detector, probability, input ready);
  modport sink(input valid, mode, detector, probability, output ready);
endinterface

interface kofn_out_if;
  import kofn_pkg::*;
  logic              valid;
  logic              ready;
  logic              detected;
  logic [CNT_W-1:0]  event_count;
  logic [PROB_W-1:0] ema_level;
  logic [PROB_W-1:0] peak_level;
  logic [HITS_W-1:0] hits_in_window;
  logic [COOL_W-1:0] cooldown_left;
  modport source(output valid, detected, event_count, ema_level, peak_level,
                 hits_in_window, cooldown_left, input ready);
  modport sink(input valid, detected, event_count, ema_level, peak_level,
               hits_in_window, cooldown_left, output ready);
endinterface

[hdl/kofn_update.sv]
// Per-detector state update: scoring, window tally, cooldown, average and peak.
module kofn_update #(
  parameter int WINDOW = 15
) (
  input  kofn_pkg::kofn_entry_t  cur_i,
  input  logic                   mode_i,
  input  logic [2:0]             det_i,
  input  logic [12:0]            prob_i,
  input  kofn_pkg::kofn_cfg_t    cfg_i,
  output kofn_pkg::kofn_entry_t  nxt_o,
  output kofn_pkg::kofn_result_t res_o
);
  import kofn_pkg::*;

  localparam logic [HIST_W-1:0] WIN_MASK = HIST_W'((1 << WINDOW) - 1);

  logic [PROB_W-1:0]        p_sat;
  logic [PROB_W-1:0]        thr_sel;
  logic [PROB_W-1:0]        w_sat;
  logic [HITS_W-1:0]        need;
  logic                     hot;
  logic                     oldest;
  logic [HITS_W-1:0]        hits_sh;
  logic [HIST_W-1:0]        hist_sh;
  logic signed [13:0]       w_s;
  logic signed [13:0]       diff_s;
  logic signed [27:0]       prod_s;
  logic signed [27:0]       rnd_s;
  logic signed [15:0]       ema_s;
  logic                     fire;

  always_comb begin
    p_sat   = sat_one(prob_i);
    w_sat   = sat_one(cfg_i.ema_w);
    thr_sel = (det_i < 3'(NUM_THR)) ? cfg_i.thr[det_i] : '1;
    need    = HITS_W'(cfg_i.need_table >> {det_i, 2'b00});
    hot     = (p_sat >= thr_sel);
    oldest  = cur_i.hist[WINDOW-1];
    hits_sh = cur_i.hits + {3'b000, hot} - {3'b000, oldest};
    hist_sh = {cur_i.hist[HIST_W-2:0], hot} & WIN_MASK;

    // ema + w*(p-ema)/4096, rounded half up
    w_s    = $signed({1'b0, w_sat});
    diff_s = $signed({1'b0, p_sat}) - $signed({1'b0, cur_i.ema});
    prod_s = w_s * diff_s;
    rnd_s  = prod_s + 28'sd2048;
    ema_s  = $signed({3'b000, cur_i.ema}) + $signed(rnd_s[27:12]);

    nxt_o = cur_i;
    fire  = 1'b0;
    res_o = '0;
    if (mode_i) begin
      nxt_o.peak       = '0;
      res_o.peak_level = cur_i.peak;
    end else begin
      nxt_o.ema  = ema_s[PROB_W-1:0];
      nxt_o.peak = (p_sat > cur_i.peak) ? p_sat : cur_i.peak;
      nxt_o.hits = hits_sh;
      nxt_o.hist = hist_sh;
      if (cur_i.cool != '0) begin
        nxt_o.cool = cur_i.cool - 8'd1;
      end else if (hits_sh >= need) begin
        fire         = 1'b1;
        nxt_o.events = cur_i.events + 32'd1;
        nxt_o.cool   = cfg_i.cool_len;
        nxt_o.hist   = '0;
        nxt_o.hits   = '0;
      end
      res_o.peak_level = nxt_o.peak;
    end
    res_o.detected       = fire;
    res_o.event_count    = nxt_o.events;
    res_o.ema_level      = nxt_o.ema;
    res_o.hits_in_window = nxt_o.hits;
    res_o.cooldown_left  = nxt_o.cool;
  end

endmodule

[hdl/k_of_n_event_detector_core.sv]
// Top level of the k-of-n sliding-window event detector.
// Usage:
//   in_ch carries one item per detector frame: mode 0 scores a probability,
//   mode 1 reads the average and peak of a detector and clears its peak.
//   out_ch returns exactly one result item per input item, in order.
//   cfg_* is an APB write/read port for thresholds, minimum hit counts,
//   cooldown length and average weight (byte address 4*index).
// Pipeline: two register stages, the update stage loaded at acceptance and the
//   result register, which holds the result until the receiver takes it.
// Throughput: 1 item per cycle unless out_ch stalls; per-detector state is read
//   at acceptance and written back when the update stage advances, with
//   write-to-read bypass for back-to-back items on the same detector.
// Reset: all detector state reads as zero (per-entry valid bits), registers
//   return to their defaults, both channels come up empty.
// Stall: when the receiver holds out_ch.ready low, the result register and
//   one item in the update stage hold, and in_ch.ready drops until space frees.
// An out-of-range detector index changes no state and yields an all-zero result.
module k_of_n_event_detector_core #(
  parameter int DETECTORS = 5,
  parameter int WINDOW    = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kofn_in_if.sink                       in_ch,
  kofn_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [kofn_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [kofn_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [kofn_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import kofn_pkg::*;

  localparam int AW = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;

  kofn_cfg_t    cfg_r;
  kofn_entry_t  mem [DETECTORS];
  logic [DETECTORS-1:0] vld_r;

  logic              s1_valid_r;
  logic              s1_mode_r;
  logic              s1_bad_r;
  logic [DET_W-1:0]  s1_det_r;
  logic [PROB_W-1:0] s1_prob_r;
  logic [AW-1:0]     s1_addr_r;
  kofn_entry_t       rd_data_r;

  logic              out_valid_r;
  kofn_result_t      out_r;

  logic              in_fire;
  logic              in_bad;
  logic [AW-1:0]     rd_addr;
  logic              s1_adv;
  logic              wr_en;
  kofn_entry_t       upd_nxt;
  kofn_result_t      upd_res;
  logic              cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr[0]      <= 13'd2867;
      cfg_r.thr[1]      <= 13'd3686;
      cfg_r.thr[2]      <= 13'd2048;
      cfg_r.thr[3]      <= 13'd2048;
      cfg_r.thr[4]      <= 13'd2867;
      cfg_r.need_table  <= 20'd140114;
      cfg_r.cool_len    <= 8'd66;
      cfg_r.ema_w       <= 13'd1434;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_paddr[4:2]))
        REG_THR0:       cfg_r.thr[0]     <= cfg_pwdata[PROB_W-1:0];
        REG_THR1:       cfg_r.thr[1]     <= cfg_pwdata[PROB_W-1:0];
        REG_THR2:       cfg_r.thr[2]     <= cfg_pwdata[PROB_W-1:0];
        REG_THR3:       cfg_r.thr[3]     <= cfg_pwdata[PROB_W-1:0];
        REG_THR4:       cfg_r.thr[4]     <= cfg_pwdata[PROB_W-1:0];
        REG_MIN_HITS:   cfg_r.need_table <= cfg_pwdata[MINH_W-1:0];
        REG_COOLDOWN:   cfg_r.cool_len   <= cfg_pwdata[COOL_W-1:0];
        REG_EMA_WEIGHT: cfg_r.ema_w      <= cfg_pwdata[PROB_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[4:2]))
      REG_THR0:       cfg_prdata = CFG_DW'(cfg_r.thr[0]);
      REG_THR1:       cfg_prdata = CFG_DW'(cfg_r.thr[1]);
      REG_THR2:       cfg_prdata = CFG_DW'(cfg_r.thr[2]);
      REG_THR3:       cfg_prdata = CFG_DW'(cfg_r.thr[3]);
      REG_THR4:       cfg_prdata = CFG_DW'(cfg_r.thr[4]);
      REG_MIN_HITS:   cfg_prdata = CFG_DW'(cfg_r.need_table);
      REG_COOLDOWN:   cfg_prdata = CFG_DW'(cfg_r.cool_len);
      REG_EMA_WEIGHT: cfg_prdata = CFG_DW'(cfg_r.ema_w);
    endcase
  end

  // handshake and pipeline control
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_bad       = (in_ch.detector >= DET_W'(DETECTORS));
  assign rd_addr      = in_ch.detector[AW-1:0];
  assign wr_en        = s1_adv && !s1_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_ch.mode;
      s1_bad_r  <= in_bad;
      s1_det_r  <= in_ch.detector;
      s1_prob_r <= in_ch.probability;
      s1_addr_r <= rd_addr;
    end
  end

  // state memory: read at acceptance, write back from the update stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= upd_nxt;
    end
    if (in_fire) begin
      if (in_bad) begin
        rd_data_r <= '0;
      end else if (wr_en && (s1_addr_r == rd_addr)) begin
        rd_data_r <= upd_nxt;
      end else if (vld_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_addr_r] <= 1'b1;
    end
  end

  kofn_update #(
    .WINDOW (WINDOW)
  ) u_update (
    .cur_i  (rd_data_r),
    .mode_i (s1_mode_r),
    .det_i  (s1_det_r),
    .prob_i (s1_prob_r),
    .cfg_i  (cfg_r),
    .nxt_o  (upd_nxt),
    .res_o  (upd_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= s1_bad_r ? '0 : upd_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.detected       = out_r.detected;
  assign out_ch.event_count    = out_r.event_count;
  assign out_ch.ema_level      = out_r.ema_level;
  assign out_ch.peak_level     = out_r.peak_level;
  assign out_ch.hits_in_window = out_r.hits_in_window;
  assign out_ch.cooldown_left  = out_r.cooldown_left;

endmodule

[hdl/kofn_checker.sv]
// Port-level checker of the event detector core and its bind.
module kofn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_detected,
  input logic [31:0] out_event_count,
  input logic [12:0] out_ema_level,
  input logic [12:0] out_peak_level,
  input logic [3:0]  out_hits_in_window
);

  a_out_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_event_count) && $stable(out_ema_level))
    else $error("result payload changed while stalled");

  a_event_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_detected |-> out_hits_in_window == 4'd0 && out_event_count != 32'd0)
    else $error("event fired without clearing window");

  a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ema_level <= 13'd4096 && out_peak_level <= 13'd4096)
    else $error("level above full scale");

endmodule

bind k_of_n_event_detector_core kofn_checker u_kofn_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_detected       (out_ch.detected),
  .out_event_count    (out_ch.event_count),
  .out_ema_level      (out_ch.ema_level),
  .out_peak_level     (out_ch.peak_level),
  .out_hits_in_window (out_ch.hits_in_window)
);

[bench/testbench.sv]
// Self-checking bench for the k-of-n event detector core: directed and random items, checked.
`timescale 1ns / 1ps

module testbench;
  import kofn_pkg::*;

  localparam int DET_COUNT      = 5;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic {MODE_FRAME, MODE_PANEL} frame_mode_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  kofn_in_if  in_ch();
  kofn_out_if out_ch();

  k_of_n_event_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // register copies
  logic [PROB_W-1:0] thr_cfg [DET_COUNT];
  logic [MINH_W-1:0] need_cfg;
  logic [COOL_W-1:0] cool_len_cfg;
  logic [PROB_W-1:0] ema_w_cfg;

  // per-detector state
  logic [HIST_W-1:0] window_bits [DET_COUNT];
  logic [HITS_W-1:0] hot_count   [DET_COUNT];
  logic [COOL_W-1:0] cool_left   [DET_COUNT];
  logic [PROB_W-1:0] avg_level   [DET_COUNT];
  logic [PROB_W-1:0] peak_level  [DET_COUNT];
  logic [CNT_W-1:0]  fired_count [DET_COUNT];

  kofn_result_t awaited_reports[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int idle_cycles;
  int reports_checked;
  int frames_sent;
  int panel_reads;
  int stray_items;
  int events_fired;
  int settings_applied;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic kofn_result_t advance_detector(frame_mode_t mode,
                                                    logic [DET_W-1:0] det,
                                                    logic [PROB_W-1:0] prob);
    kofn_result_t r;
    logic [PROB_W-1:0] p;
    logic [PROB_W-1:0] w;
    logic [31:0] acc;
    logic hot;
    logic oldest;
    logic [HITS_W-1:0] need;
    int d;
    r = '0;
    if (det >= DET_COUNT) return r;
    d = int'(det);
    p = (prob > ONE_FIX) ? ONE_FIX : prob;
    if (mode == MODE_PANEL) begin
      r.peak_level = peak_level[d];
      peak_level[d] = '0;
    end else begin
      w = (ema_w_cfg > ONE_FIX) ? ONE_FIX : ema_w_cfg;
      hot = (p >= thr_cfg[d]);
      oldest = window_bits[d][HIST_W-1];
      need = need_cfg[4*d +: 4];
      acc = 32'(w) * 32'(p) + (32'd4096 - 32'(w)) * 32'(avg_level[d]) + 32'd2048;
      acc = acc >> 12;
      avg_level[d] = (acc > 32'd4096) ? ONE_FIX : acc[PROB_W-1:0];
      if (p > peak_level[d]) peak_level[d] = p;
      hot_count[d] = hot_count[d] + {3'b000, hot} - {3'b000, oldest};
      window_bits[d] = {window_bits[d][HIST_W-2:0], hot};
      if (cool_left[d] != 0) begin
        cool_left[d] = cool_left[d] - 8'd1;
      end else if (hot_count[d] >= need) begin
        fired_count[d] = fired_count[d] + 32'd1;
        cool_left[d] = cool_len_cfg;
        window_bits[d] = '0;
        hot_count[d] = '0;
        r.detected = 1'b1;
      end
      r.peak_level = peak_level[d];
    end
    r.event_count = fired_count[d];
    r.ema_level = avg_level[d];
    r.hits_in_window = hot_count[d];
    r.cooldown_left = cool_left[d];
    return r;
  endfunction

  task automatic send_item(frame_mode_t mode, logic [DET_W-1:0] det, logic [PROB_W-1:0] prob);
    kofn_result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.detector <= det;
    in_ch.probability <= prob;
    do @(posedge clk); while (!in_ch.ready);
    r = advance_detector(mode, det, prob);
    awaited_reports.push_back(r);
    if (det >= DET_COUNT) stray_items++;
    else if (mode == MODE_PANEL) panel_reads++;
    else frames_sent++;
    if (r.detected) events_fired++;
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(cfg_reg_t idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_THR0, REG_THR1, REG_THR2, REG_THR3, REG_THR4: thr_cfg[int'(idx)] = value[PROB_W-1:0];
      REG_MIN_HITS:   need_cfg = value[MINH_W-1:0];
      REG_COOLDOWN:   cool_len_cfg = value[COOL_W-1:0];
      REG_EMA_WEIGHT: ema_w_cfg = value[PROB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic reg_read_check(cfg_reg_t idx);
    logic [CFG_DW-1:0] want;
    case (idx)
      REG_THR0, REG_THR1, REG_THR2, REG_THR3, REG_THR4: want = 32'(thr_cfg[int'(idx)]);
      REG_MIN_HITS:   want = 32'(need_cfg);
      REG_COOLDOWN:   want = 32'(cool_len_cfg);
      default:        want = 32'(ema_w_cfg);
    endcase
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      report_mismatch($sformatf("register %s read %0h want %0h", idx.name(), cfg_prdata, want));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_settings(logic [NUM_THR-1:0][PROB_W-1:0] thr,
                                  logic [MINH_W-1:0] need_table,
                                  logic [COOL_W-1:0] cool_len,
                                  logic [PROB_W-1:0] ema_w);
    drain_reports();
    for (int i = 0; i < NUM_THR; i++) reg_write(cfg_reg_t'(REG_THR0 + i), 32'(thr[i]));
    reg_write(REG_MIN_HITS, 32'(need_table));
    reg_write(REG_COOLDOWN, 32'(cool_len));
    reg_write(REG_EMA_WEIGHT, 32'(ema_w));
    for (int i = 0; i <= REG_EMA_WEIGHT; i++) reg_read_check(cfg_reg_t'(i));
    settings_applied++;
  endtask

  task automatic program_random_settings(int cool_lo, int cool_hi, int ema_lo, int ema_hi);
    logic [NUM_THR-1:0][PROB_W-1:0] thr;
    logic [MINH_W-1:0] need_table;
    for (int i = 0; i < NUM_THR; i++)
      thr[i] = ($urandom_range(99) < 85) ? PROB_W'($urandom_range(4096))
                                         : PROB_W'($urandom_range(8191, 4097));
    for (int i = 0; i < DET_COUNT; i++) need_table[4*i +: 4] = HITS_W'($urandom_range(15));
    program_settings(thr, need_table, COOL_W'($urandom_range(cool_hi, cool_lo)),
                     PROB_W'($urandom_range(ema_hi, ema_lo)));
  endtask

  // mostly runs of frames on one detector, with a few panel reads and stray indexes
  task automatic send_random_item(inout logic [DET_W-1:0] last_det, input int det_hi);
    frame_mode_t mode;
    logic [DET_W-1:0] det;
    logic [PROB_W-1:0] prob;
    logic [PROB_W-1:0] thr;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) det = DET_W'($urandom_range(7, DET_COUNT));
    else if (pick < 40 || last_det >= DET_COUNT || last_det > det_hi)
      det = DET_W'($urandom_range(det_hi));
    else det = last_det;
    last_det = det;
    mode = ($urandom_range(99) < 10) ? MODE_PANEL : MODE_FRAME;
    thr = (det < DET_COUNT) ? thr_cfg[det] : 13'd2048;
    pick = $urandom_range(99);
    if (pick < 30) begin
      prob = PROB_W'($urandom_range(4096));
    end else if (pick < 55) begin
      prob = (thr <= ONE_FIX) ? PROB_W'($urandom_range(4096, thr))
                              : PROB_W'($urandom_range(4096));
    end else if (pick < 75) begin
      if (thr == 0) prob = '0;
      else prob = (thr > ONE_FIX) ? PROB_W'($urandom_range(4096))
                                  : PROB_W'($urandom_range(thr - 13'd1));
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0:       prob = '0;
        1:       prob = ONE_FIX;
        2:       prob = thr;
        default: prob = thr - 13'd1;
      endcase
    end else begin
      prob = PROB_W'($urandom_range(8191));
    end
    send_item(mode, det, prob);
  endtask

  task automatic test_register_defaults();
    for (int i = 0; i <= REG_EMA_WEIGHT; i++) reg_read_check(cfg_reg_t'(i));
  endtask

  task automatic test_directed_items();
    send_item(MODE_PANEL, 3'd0, 13'd0);
    send_item(MODE_FRAME, 3'd0, 13'd0);
    send_item(MODE_FRAME, 3'd0, 13'd8191);
    send_item(MODE_FRAME, 3'd0, 13'd4097);
    send_item(MODE_FRAME, 3'd0, 13'd4096);
    send_item(MODE_PANEL, 3'd0, 13'd4096);
    send_item(MODE_PANEL, 3'd0, 13'd0);
    send_item(MODE_FRAME, 3'd1, 13'd3685);
    send_item(MODE_FRAME, 3'd1, 13'd3686);
    send_item(MODE_FRAME, 3'd5, 13'd8191);
    send_item(MODE_PANEL, 3'd6, 13'd0);
    send_item(MODE_FRAME, 3'd7, 13'd4096);
    repeat (3) send_item(MODE_FRAME, 3'd2, 13'd2048);
    send_item(MODE_FRAME, 3'd3, 13'd2047);
    send_item(MODE_FRAME, 3'd4, 13'd6000);
    send_item(MODE_PANEL, 3'd4, 13'd8191);
    send_item(MODE_FRAME, 3'd2, 13'd0);
    drain_reports();
  endtask

  // always-hot, never-hot, thresholds at and past 1.0, minimum 0 and 15, no cooldown
  task automatic test_config_extremes();
    logic [DET_W-1:0] last_det;
    last_det = '0;
    program_settings({13'd1, 13'd4097, 13'd4096, 13'd8191, 13'd0}, 20'h8310F, 8'd0, 13'd8191);
    repeat (250) send_random_item(last_det, DET_COUNT - 1);
    drain_reports();
  endtask

  task automatic test_random_settings();
    logic [DET_W-1:0] last_det;
    last_det = '0;
    program_random_settings(255, 255, 0, 0);
    repeat (100) send_random_item(last_det, DET_COUNT - 1);
    repeat (2) begin
      program_random_settings(0, 30, 0, 8191);
      repeat (175) send_random_item(last_det, DET_COUNT - 1);
    end
    drain_reports();
  endtask

  // dense traffic on two detectors exercises back-to-back updates of one entry
  task automatic test_back_to_back();
    logic [DET_W-1:0] last_det;
    last_det = '0;
    program_random_settings(0, 8, 4096, 4096);
    repeat (215) send_random_item(last_det, 1);
    program_random_settings(0, 12, 0, 8191);
    repeat (215) send_random_item(last_det, 1);
    drain_reports();
  endtask

  always @(negedge clk)
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_reports
    kofn_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_checked++;
      if (awaited_reports.size() == 0) begin
        report_mismatch("result item with nothing pending");
      end else begin
        want = awaited_reports.pop_front();
        if (out_ch.detected !== want.detected)
          report_mismatch($sformatf("detected %0d want %0d", out_ch.detected, want.detected));
        if (out_ch.event_count !== want.event_count)
          report_mismatch($sformatf("event_count %0d want %0d",
                                    out_ch.event_count, want.event_count));
        if (out_ch.ema_level !== want.ema_level)
          report_mismatch($sformatf("ema_level %0d want %0d", out_ch.ema_level, want.ema_level));
        if (out_ch.peak_level !== want.peak_level)
          report_mismatch($sformatf("peak_level %0d want %0d",
                                    out_ch.peak_level, want.peak_level));
        if (out_ch.hits_in_window !== want.hits_in_window)
          report_mismatch($sformatf("hits_in_window %0d want %0d",
                                    out_ch.hits_in_window, want.hits_in_window));
        if (out_ch.cooldown_left !== want.cooldown_left)
          report_mismatch($sformatf("cooldown_left %0d want %0d",
                                    out_ch.cooldown_left, want.cooldown_left));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without progress, %0d results pending",
               idle_cycles, awaited_reports.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.detector = '0;
    in_ch.probability = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    reports_checked = 0;
    frames_sent = 0;
    panel_reads = 0;
    stray_items = 0;
    events_fired = 0;
    settings_applied = 0;
    send_idle_pct = 19;
    recv_stall_pct = 54;
    thr_cfg = '{13'd2867, 13'd3686, 13'd2048, 13'd2048, 13'd2867};
    need_cfg = 20'd140114;
    cool_len_cfg = 8'd66;
    ema_w_cfg = 13'd1434;
    for (int i = 0; i < DET_COUNT; i++) begin
      window_bits[i] = '0;
      hot_count[i] = '0;
      cool_left[i] = '0;
      avg_level[i] = '0;
      peak_level[i] = '0;
      fired_count[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_directed_items();
    test_config_extremes();
    send_idle_pct = 54;
    recv_stall_pct = 19;
    test_random_settings();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_back_to_back();

    drain_reports();
    repeat (10) @(posedge clk);
    if (awaited_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));
    $display("covered %0d frames, %0d panel reads, %0d out-of-range items, %0d events",
             frames_sent, panel_reads, stray_items, events_fired);
    $display("checked %0d results over %0d register settings, %0d mismatches",
             reports_checked, settings_applied, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
